/* rtl/core/set_assoc_writeback_cache_tags_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cache tag block
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_WRITEBACK_CACHE_TAGS_ASSERT_SVH
`define SET_ASSOC_WRITEBACK_CACHE_TAGS_ASSERT_SVH

// consequent checked in the same cycle
`define SAWC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sawc assertion failed");

// consequent checked in the next cycle
`define SAWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sawc assertion failed");

`endif

/* rtl/core/sawc_pkg.sv */
// ----------------------------------------------------------------------------
// sawc_pkg
// Types and constants shared by the cache tag block.
// ----------------------------------------------------------------------------
`default_nettype none

package sawc_pkg;

  localparam int DEF_SET_COUNT   = 64;
  localparam int DEF_WAY_COUNT   = 4;
  localparam int DEF_BLOCK_BYTES = 32;

  localparam int ADDR_W      = 32;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic MODE_LRU    = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_REPLACE_MODE = 1'b0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } sawc_state_t;

  typedef struct packed {
    logic start;
    logic capture;
  } sawc_scan_ctl_t;

  // hit in the lowest bit
  typedef struct packed {
    logic [ADDR_W-1:0] fetch;
    logic [ADDR_W-1:0] victim;
    logic              wb;
    logic [1:0]        way_used;
    logic              hit;
  } sawc_result_t;

endpackage

`default_nettype wire

/* rtl/core/sawc_store.sv */
// ----------------------------------------------------------------------------
// sawc_store
// Line store: valid/dirty/tag memory and recency rank memory, one read
// address and one write address per memory per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sawc_store
  import sawc_pkg::*;
#(
  parameter int LINES  = DEF_SET_COUNT * DEF_WAY_COUNT,
  parameter int LINE_W = 8,
  parameter int TAG_W  = 21,
  parameter int RANK_W = 2
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [LINE_W-1:0] rd_addr,
  input  logic              meta_we,
  input  logic [LINE_W-1:0] meta_waddr,
  input  logic [TAG_W+1:0]  meta_wdata,
  input  logic              rank_we,
  input  logic [LINE_W-1:0] rank_waddr,
  input  logic [RANK_W-1:0] rank_wdata,
  output logic [TAG_W+1:0]  meta_rd_r,
  output logic [RANK_W-1:0] rank_rd_r
);

  // meta word: {valid, dirty, tag}
  logic [TAG_W+1:0]  meta_mem [LINES];
  logic [RANK_W-1:0] rank_mem [LINES];

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (rank_we) begin
      rank_mem[rank_waddr] <= rank_wdata;
    end
    if (rd_en) begin
      meta_rd_r <= meta_mem[rd_addr];
      rank_rd_r <= rank_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sawc_scan.sv */
// ----------------------------------------------------------------------------
// sawc_scan
// Way scan unit: one tag compare and one rank compare per cycle, gathering
// hit, first invalid way, least recent way and valid count over a set.
// ----------------------------------------------------------------------------
`default_nettype none

module sawc_scan
  import sawc_pkg::*;
#(
  parameter int WAY_COUNT = DEF_WAY_COUNT,
  parameter int WAY_W     = 2,
  parameter int RANK_W    = 2,
  parameter int CNT_W     = 3,
  parameter int TAG_W     = 21
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sawc_scan_ctl_t    ctl,
  input  logic [WAY_W-1:0]  way,
  input  logic [TAG_W-1:0]  search_tag,
  input  logic              rd_valid,
  input  logic              rd_dirty,
  input  logic [TAG_W-1:0]  rd_tag,
  input  logic [RANK_W-1:0] rd_rank,
  input  logic [WAY_W-1:0]  sel_way,
  output logic              hit_r,
  output logic [WAY_W-1:0]  hit_way_r,
  output logic [RANK_W-1:0] hit_rank_r,
  output logic              inv_found_r,
  output logic [WAY_W-1:0]  inv_way_r,
  output logic [WAY_W-1:0]  min_way_r,
  output logic [RANK_W-1:0] min_rank_r,
  output logic              min_dirty_r,
  output logic [TAG_W-1:0]  min_tag_r,
  output logic [CNT_W-1:0]  n_valid_r,
  output logic              sel_valid,
  output logic [RANK_W-1:0] sel_rank
);

  logic              min_found_r;
  logic              way_valid_r [WAY_COUNT];
  logic [RANK_W-1:0] way_rank_r  [WAY_COUNT];
  logic              tag_eq;
  logic              rank_lt;

  assign tag_eq  = rd_valid && (rd_tag == search_tag);
  assign rank_lt = !min_found_r || (rd_rank < min_rank_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      inv_found_r <= 1'b0;
      min_found_r <= 1'b0;
      n_valid_r   <= '0;
    end else if (ctl.start) begin
      hit_r       <= 1'b0;
      inv_found_r <= 1'b0;
      min_found_r <= 1'b0;
      n_valid_r   <= '0;
    end else if (ctl.capture) begin
      if (rd_valid) begin
        n_valid_r <= n_valid_r + CNT_W'(1);
      end
      if (tag_eq && !hit_r) begin
        hit_r      <= 1'b1;
        hit_way_r  <= way;
        hit_rank_r <= rd_rank;
      end
      if (!rd_valid && !inv_found_r) begin
        inv_found_r <= 1'b1;
        inv_way_r   <= way;
      end
      if (rd_valid && rank_lt) begin
        min_found_r <= 1'b1;
        min_way_r   <= way;
        min_rank_r  <= rd_rank;
        min_dirty_r <= rd_dirty;
        min_tag_r   <= rd_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      way_valid_r[way] <= rd_valid;
      way_rank_r[way]  <= rd_rank;
    end
  end

  assign sel_valid = way_valid_r[sel_way];
  assign sel_rank  = way_rank_r[sel_way];

endmodule

`default_nettype wire

/* rtl/core/sawc_ctrl.sv */
// ----------------------------------------------------------------------------
// sawc_ctrl
// Sequencer: clearing pass after reset, way scan, rank and line update,
// result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module sawc_ctrl
  import sawc_pkg::*;
#(
  parameter int SET_COUNT   = DEF_SET_COUNT,
  parameter int WAY_COUNT   = DEF_WAY_COUNT,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES,
  parameter int OB          = 5,
  parameter int IB          = 6,
  parameter int TAG_W       = 21,
  parameter int SIDX_W      = 6,
  parameter int LINES       = DEF_SET_COUNT * DEF_WAY_COUNT,
  parameter int LINE_W      = 8,
  parameter int WAY_W       = 2,
  parameter int RANK_W      = 2,
  parameter int CNT_W       = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              replace_mode,
  input  logic              in_valid,
  input  logic              in_action,
  input  logic [ADDR_W-1:0] in_address,
  output logic              in_ready,
  output logic              res_valid,
  input  logic              res_ready,
  output sawc_result_t      res,
  output logic              rd_en,
  output logic [LINE_W-1:0] rd_addr,
  output logic              meta_we,
  output logic [LINE_W-1:0] meta_waddr,
  output logic [TAG_W+1:0]  meta_wdata,
  output logic              rank_we,
  output logic [LINE_W-1:0] rank_waddr,
  output logic [RANK_W-1:0] rank_wdata,
  output sawc_scan_ctl_t    scan_ctl,
  output logic [WAY_W-1:0]  scan_way,
  output logic [TAG_W-1:0]  search_tag,
  output logic [WAY_W-1:0]  sel_way,
  input  logic              hit,
  input  logic [WAY_W-1:0]  hit_way,
  input  logic [RANK_W-1:0] hit_rank,
  input  logic              inv_found,
  input  logic [WAY_W-1:0]  inv_way,
  input  logic [WAY_W-1:0]  min_way,
  input  logic [RANK_W-1:0] min_rank,
  input  logic              min_dirty,
  input  logic [TAG_W-1:0]  min_tag,
  input  logic [CNT_W-1:0]  n_valid,
  input  logic              sel_valid,
  input  logic [RANK_W-1:0] sel_rank
);

  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'((64'd1 << OB) - 64'd1);
  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'(SET_COUNT - 1);
  localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(WAY_COUNT - 1);
  localparam logic [CNT_W-1:0]  CNT_END  = CNT_W'(WAY_COUNT);
  localparam logic [LINE_W-1:0] CLR_LAST = LINE_W'(LINES - 1);

  sawc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [LINE_W-1:0] clr_r, clr_nxt;
  logic              action_r;
  logic [ADDR_W-1:0] addr_r;
  logic [SIDX_W-1:0] set_r, set_nxt;
  logic [TAG_W-1:0]  tag_r;
  logic [LINE_W-1:0] base_r;

  logic [WAY_W-1:0]  tgt_way;
  logic              was_valid;
  logic [RANK_W-1:0] ref_rank;
  logic              refresh;
  logic              meta_upd;
  logic [RANK_W-1:0] new_rank;
  logic              wb;
  logic [WAY_W-1:0]  cur_way;
  logic [LINE_W-1:0] cur_addr;

  assign set_nxt = SIDX_W'((in_address >> OB) & SET_MASK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_r <= in_action;
      addr_r   <= in_address;
      set_r    <= set_nxt;
      tag_r    <= TAG_W'(in_address >> (OB + IB));
      base_r   <= LINE_W'(32'(set_nxt) * 32'(WAY_COUNT));
    end
  end

  // update decisions, stable once the scan is complete
  assign tgt_way   = hit ? hit_way : (inv_found ? inv_way : min_way);
  assign was_valid = hit || !inv_found;
  assign ref_rank  = hit ? hit_rank : min_rank;
  assign refresh   = !hit || (action_r == ACT_WRITE) || (replace_mode == MODE_LRU);
  assign meta_upd  = !hit || (action_r == ACT_WRITE);
  assign new_rank  = was_valid ? RANK_W'(n_valid - CNT_W'(1)) : RANK_W'(n_valid);
  assign wb        = !hit && !inv_found && min_dirty;

  assign cur_way    = WAY_W'(cnt_r);
  assign cur_addr   = base_r + LINE_W'(cnt_r);
  assign search_tag = tag_r;
  assign sel_way    = cur_way;
  assign scan_way   = WAY_W'(cnt_r - CNT_W'(1));

  always_comb begin
    res.hit      = hit;
    res.way_used = 2'(tgt_way);
    res.wb       = wb;
    res.victim   = wb ? (((ADDR_W'(min_tag) << IB) + ADDR_W'(set_r)) << OB) : '0;
    res.fetch    = hit ? '0 : (addr_r & ~OFF_MASK);
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    clr_nxt          = clr_r;
    in_ready         = 1'b0;
    res_valid        = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = cur_addr;
    meta_we          = 1'b0;
    meta_waddr       = cur_addr;
    meta_wdata       = {1'b1, action_r, tag_r};
    rank_we          = 1'b0;
    rank_waddr       = cur_addr;
    rank_wdata       = sel_rank - RANK_W'(1);
    scan_ctl.start   = 1'b0;
    scan_ctl.capture = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
        clr_nxt    = clr_r + LINE_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          scan_ctl.start = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en            = (cnt_r != CNT_END);
        scan_ctl.capture = (cnt_r != '0);
        if (cnt_r == CNT_END) begin
          cnt_nxt   = '0;
          state_nxt = ST_UPDATE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_UPDATE: begin
        if (cur_way == tgt_way) begin
          meta_we    = meta_upd;
          rank_we    = refresh;
          rank_wdata = new_rank;
        end else begin
          rank_we = refresh && was_valid && sel_valid && (sel_rank > ref_rank);
        end
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/set_assoc_writeback_cache_tags.sv */
// Flow: a request is accepted only in ST_IDLE, then scanned, the line and ranks
// updated, and its result registered onto out_tvalid; the next request is taken
// after that hand-off, which waits while a result is held without out_tready.
// Scan reads one way per cycle, then one way's line and rank per cycle.
// Reset: rst_n clears control and replace_mode, then a clearing pass over all
// SET_COUNT*WAY_COUNT lines (256) runs with in_tready low; cfg writes taken.
// ----------------------------------------------------------------------------
// set_assoc_writeback_cache_tags
// Tag and control array of a set-associative write-back cache with
// rank-based recency replacement.
// ----------------------------------------------------------------------------
`default_nettype none

module set_assoc_writeback_cache_tags
  import sawc_pkg::*;
#(
  parameter int SET_COUNT   = DEF_SET_COUNT,
  parameter int WAY_COUNT   = DEF_WAY_COUNT,
  parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // address[31:0]
  input  logic                   in_tuser,   // action
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // hit, way_used[1:0], writeback_needed,
                                             // victim_address[31:0], fetch_address[31:0]
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [CFG_DATA_W-1:0]  cfg_prdata,
  output logic                   cfg_pready
);

  localparam int OB     = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int IB     = $clog2(SET_COUNT + 1) - 1;
  localparam int TAG_W  = ADDR_W - OB - IB;
  localparam int SIDX_W = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int LINES  = SET_COUNT * WAY_COUNT;
  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int WAY_W  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int RANK_W = WAY_W;
  localparam int CNT_W  = $clog2(WAY_COUNT + 1);

  logic              replace_mode_r;
  logic              cfg_wr;
  logic              out_valid_r;
  sawc_result_t      out_res_r;

  logic              res_valid;
  logic              res_ready;
  sawc_result_t      res;
  logic              rd_en;
  logic [LINE_W-1:0] rd_addr;
  logic              meta_we;
  logic [LINE_W-1:0] meta_waddr;
  logic [TAG_W+1:0]  meta_wdata;
  logic              rank_we;
  logic [LINE_W-1:0] rank_waddr;
  logic [RANK_W-1:0] rank_wdata;
  logic [TAG_W+1:0]  meta_rd;
  logic [RANK_W-1:0] rank_rd;
  sawc_scan_ctl_t    scan_ctl;
  logic [WAY_W-1:0]  scan_way;
  logic [TAG_W-1:0]  search_tag;
  logic [WAY_W-1:0]  sel_way;
  logic              hit;
  logic [WAY_W-1:0]  hit_way;
  logic [RANK_W-1:0] hit_rank;
  logic              inv_found;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  min_way;
  logic [RANK_W-1:0] min_rank;
  logic              min_dirty;
  logic [TAG_W-1:0]  min_tag;
  logic [CNT_W-1:0]  n_valid;
  logic              sel_valid;
  logic [RANK_W-1:0] sel_rank;

  // configuration
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_REPLACE_MODE) ?
                      CFG_DATA_W'(replace_mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      replace_mode_r <= MODE_LRU;
    end else if (cfg_wr && (cfg_paddr[2] == REG_REPLACE_MODE)) begin
      replace_mode_r <= cfg_pwdata[0];
    end
  end

  // result register
  assign res_ready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  sawc_ctrl #(
    .SET_COUNT   (SET_COUNT),
    .WAY_COUNT   (WAY_COUNT),
    .BLOCK_BYTES (BLOCK_BYTES),
    .OB          (OB),
    .IB          (IB),
    .TAG_W       (TAG_W),
    .SIDX_W      (SIDX_W),
    .LINES       (LINES),
    .LINE_W      (LINE_W),
    .WAY_W       (WAY_W),
    .RANK_W      (RANK_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .replace_mode (replace_mode_r),
    .in_valid     (in_tvalid),
    .in_action    (in_tuser),
    .in_address   (in_tdata),
    .in_ready     (in_tready),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .meta_we      (meta_we),
    .meta_waddr   (meta_waddr),
    .meta_wdata   (meta_wdata),
    .rank_we      (rank_we),
    .rank_waddr   (rank_waddr),
    .rank_wdata   (rank_wdata),
    .scan_ctl     (scan_ctl),
    .scan_way     (scan_way),
    .search_tag   (search_tag),
    .sel_way      (sel_way),
    .hit          (hit),
    .hit_way      (hit_way),
    .hit_rank     (hit_rank),
    .inv_found    (inv_found),
    .inv_way      (inv_way),
    .min_way      (min_way),
    .min_rank     (min_rank),
    .min_dirty    (min_dirty),
    .min_tag      (min_tag),
    .n_valid      (n_valid),
    .sel_valid    (sel_valid),
    .sel_rank     (sel_rank)
  );

  sawc_store #(
    .LINES  (LINES),
    .LINE_W (LINE_W),
    .TAG_W  (TAG_W),
    .RANK_W (RANK_W)
  ) u_store (
    .clk        (clk),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .meta_we    (meta_we),
    .meta_waddr (meta_waddr),
    .meta_wdata (meta_wdata),
    .rank_we    (rank_we),
    .rank_waddr (rank_waddr),
    .rank_wdata (rank_wdata),
    .meta_rd_r  (meta_rd),
    .rank_rd_r  (rank_rd)
  );

  sawc_scan #(
    .WAY_COUNT (WAY_COUNT),
    .WAY_W     (WAY_W),
    .RANK_W    (RANK_W),
    .CNT_W     (CNT_W),
    .TAG_W     (TAG_W)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .way         (scan_way),
    .search_tag  (search_tag),
    .rd_valid    (meta_rd[TAG_W+1]),
    .rd_dirty    (meta_rd[TAG_W]),
    .rd_tag      (meta_rd[TAG_W-1:0]),
    .rd_rank     (rank_rd),
    .sel_way     (sel_way),
    .hit_r       (hit),
    .hit_way_r   (hit_way),
    .hit_rank_r  (hit_rank),
    .inv_found_r (inv_found),
    .inv_way_r   (inv_way),
    .min_way_r   (min_way),
    .min_rank_r  (min_rank),
    .min_dirty_r (min_dirty),
    .min_tag_r   (min_tag),
    .n_valid_r   (n_valid),
    .sel_valid   (sel_valid),
    .sel_rank    (sel_rank)
  );

endmodule

`default_nettype wire

/* rtl/core/sawc_port_checker.sv */
// ----------------------------------------------------------------------------
// sawc_port_checker
// Port-level checks on the cache tag block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_writeback_cache_tags_assert.svh"

module sawc_port_checker
  import sawc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // a stalled result holds
  `SAWC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // one request at a time
  `SAWC_ASSERT_NEXT(a_one_req, in_tvalid && in_tready, !in_tready)

  // a hit neither writes back nor fetches
  `SAWC_ASSERT_NOW(a_hit_quiet, out_tvalid && out_tdata[0], out_tdata[67:3] == '0)

  // victim address only with a write-back
  `SAWC_ASSERT_NOW(a_victim_zero, out_tvalid && !out_tdata[3], out_tdata[35:4] == '0)

endmodule

bind set_assoc_writeback_cache_tags sawc_port_checker u_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cache tag array testbench
// Drives read and write requests into the tag block while its stream ports
// idle at random, and scores every lookup result against its typed row or a
// behavioural copy of the tag, valid, dirty and recency state. The run starts
// with a short list of directed requests, then works through random phases
// with the replacement mode changed between them over the register port.
// ----------------------------------------------------------------------------

module testbench;
  import sawc_pkg::*;

  localparam int SETS        = DEF_SET_COUNT;
  localparam int WAYS        = DEF_WAY_COUNT;
  localparam int OFF_BITS    = 5;
  localparam int IDX_BITS    = 6;
  localparam int TAG_BITS    = ADDR_W - OFF_BITS - IDX_BITS;
  localparam int LATENCY     = 2 * WAYS + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_REQS  = 210;
  localparam int POOL_TAGS   = 6;

  localparam logic [CFG_ADDR_W-1:0] MODE_REG_ADDR   = {REG_REPLACE_MODE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] UNUSED_REG_ADDR = 3'd4;

  typedef struct {
    logic         act;
    logic [31:0]  addr;
    bit           known;
    sawc_result_t res;
  } access_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = ACT_READ;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  // behavioural copy of the line store
  logic                line_ok   [SETS*WAYS];
  logic                line_mod  [SETS*WAYS];
  logic [TAG_BITS-1:0] line_tag  [SETS*WAYS];
  logic [1:0]          line_rank [SETS*WAYS];
  logic                cur_mode;

  sawc_result_t  awaited_lookups[$];
  access_row_t   directed_accesses[$];
  logic [TAG_BITS-1:0] tag_pool[POOL_TAGS];
  int  fail_count = 0;
  int  cycle_count = 0;
  bit  steady = 1'b0;

  set_assoc_writeback_cache_tags dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // make a line most recent; lines ranked above it drop by one
  function automatic void promote_line(int base, int way, bit was_valid);
    int cnt;
    logic [1:0] old_rank;
    cnt = 0;
    if (was_valid) begin
      old_rank = line_rank[base+way];
      for (int w = 0; w < WAYS; w++)
        if (w != way && line_ok[base+w] && line_rank[base+w] > old_rank)
          line_rank[base+w] = line_rank[base+w] - 1'b1;
    end
    line_ok[base+way] = 1'b1;
    for (int w = 0; w < WAYS; w++)
      if (line_ok[base+w]) cnt++;
    line_rank[base+way] = 2'(cnt - 1);
  endfunction

  function automatic sawc_result_t lookup_line(logic act, logic [31:0] addr);
    sawc_result_t r;
    logic [IDX_BITS-1:0] set_idx;
    logic [TAG_BITS-1:0] tag;
    int base, way;
    bit hit, found_free;
    logic [1:0] best;
    set_idx = addr[OFF_BITS +: IDX_BITS];
    tag = addr[ADDR_W-1 -: TAG_BITS];
    base = int'(set_idx) * WAYS;
    way = 0;
    hit = 1'b0;
    found_free = 1'b0;
    best = '0;
    r = '0;
    for (int w = 0; w < WAYS && !hit; w++)
      if (line_ok[base+w] && line_tag[base+w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    if (hit) begin
      if (act == ACT_WRITE) begin
        line_mod[base+way] = 1'b1;
        promote_line(base, way, 1'b1);
      end else if (cur_mode == MODE_LRU) begin
        promote_line(base, way, 1'b1);
      end
    end else begin
      for (int w = 0; w < WAYS && !found_free; w++) begin
        if (!line_ok[base+w]) begin
          way = w;
          found_free = 1'b1;
        end else if (w == 0 || line_rank[base+w] < best) begin
          best = line_rank[base+w];
          way = w;
        end
      end
      if (!found_free && line_mod[base+way]) begin
        r.wb = 1'b1;
        r.victim = {line_tag[base+way], set_idx, {OFF_BITS{1'b0}}};
      end
      r.fetch = {addr[ADDR_W-1:OFF_BITS], {OFF_BITS{1'b0}}};
      line_tag[base+way] = tag;
      line_mod[base+way] = (act == ACT_WRITE);
      promote_line(base, way, !found_free);
    end
    r.hit = hit;
    r.way_used = 2'(way);
    return r;
  endfunction

  task automatic send_request(logic act, logic [31:0] addr, bit known, sawc_result_t typed);
    int gap;
    sawc_result_t r;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= addr;
    do @(posedge clk); while (!in_tready);
    r = lookup_line(act, addr);
    awaited_lookups.push_back(known ? typed : r);
  endtask

  task automatic cfg_access(logic wr, logic [CFG_ADDR_W-1:0] a, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= wr;
    cfg_paddr <= a;
    cfg_pwdata <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (wr && a[2] == REG_REPLACE_MODE)
      cur_mode = d[0];
    if (!wr && cfg_prdata != {{(CFG_DATA_W-1){1'b0}}, cur_mode}) begin
      $error("replace_mode: expected %0h, got %0h", cur_mode, cfg_prdata);
      fail_count++;
    end
  endtask

  task automatic set_mode(logic [CFG_DATA_W-1:0] d);
    cfg_access(1'b1, MODE_REG_ADDR, d);
    cfg_access(1'b0, MODE_REG_ADDR, '0);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic add_row(logic act, logic [31:0] addr, bit known, logic [67:0] res);
    access_row_t row;
    row.act = act;
    row.addr = addr;
    row.known = known;
    row.res = sawc_result_t'(res);
    directed_accesses.push_back(row);
  endtask

  task automatic random_phase(int n);
    logic act;
    logic [31:0] addr;
    logic [IDX_BITS-1:0] set_idx;
    for (int i = 0; i < POOL_TAGS; i++)
      tag_pool[i] = TAG_BITS'($urandom);
    if ($urandom_range(0, 1)) tag_pool[0] = '0;
    if ($urandom_range(0, 1)) tag_pool[1] = '1;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      act = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 9) == 0) begin
        addr = $urandom;
      end else begin
        set_idx = ($urandom_range(0, 9) < 7) ? IDX_BITS'($urandom_range(0, 3))
                                             : IDX_BITS'($urandom);
        addr = {tag_pool[$urandom_range(0, POOL_TAGS-1)], set_idx, OFF_BITS'($urandom)};
      end
      send_request(act, addr, 1'b0, '0);
    end
  endtask

  // result side
  initial begin
    sawc_result_t got, want;
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = sawc_result_t'(out_tdata[$bits(sawc_result_t)-1:0]);
      if (awaited_lookups.size() == 0) begin
        $error("unexpected result %0h", got);
        fail_count++;
      end else begin
        want = awaited_lookups.pop_front();
        if (got.hit != want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, got.hit);
          fail_count++;
        end
        if (got.way_used != want.way_used) begin
          $error("way_used: expected %0d, got %0d", want.way_used, got.way_used);
          fail_count++;
        end
        if (got.wb != want.wb) begin
          $error("writeback_needed: expected %0d, got %0d", want.wb, got.wb);
          fail_count++;
        end
        if (got.victim != want.victim) begin
          $error("victim_address: expected %h, got %h", want.victim, got.victim);
          fail_count++;
        end
        if (got.fetch != want.fetch) begin
          $error("fetch_address: expected %h, got %h", want.fetch, got.fetch);
          fail_count++;
        end
      end
    end
  end

  // request side and run control
  initial begin
    access_row_t row;
    for (int i = 0; i < SETS*WAYS; i++) begin
      line_ok[i] = 1'b0;
      line_mod[i] = 1'b0;
      line_tag[i] = '0;
      line_rank[i] = '0;
    end
    cur_mode = MODE_LRU;

    // typed rows: {fetch, victim, writeback, way, hit}
    add_row(ACT_READ,  32'h0000_0000, 1, {32'h0000_0000, 32'h0, 1'b0, 2'd0, 1'b0});
    add_row(ACT_WRITE, 32'hFFFF_FFFF, 1, {32'hFFFF_FFE0, 32'h0, 1'b0, 2'd0, 1'b0});
    add_row(ACT_READ,  32'hFFFF_FFFF, 1, {32'h0000_0000, 32'h0, 1'b0, 2'd0, 1'b1});
    add_row(ACT_WRITE, 32'hFFFF_FFE0, 1, {32'h0000_0000, 32'h0, 1'b0, 2'd0, 1'b1});
    add_row(ACT_WRITE, 32'h0000_001F, 1, {32'h0000_0000, 32'h0, 1'b0, 2'd0, 1'b1});
    add_row(ACT_WRITE, 32'h0000_0800, 1, {32'h0000_0800, 32'h0, 1'b0, 2'd1, 1'b0});
    add_row(ACT_READ,  32'h0000_1000, 1, {32'h0000_1000, 32'h0, 1'b0, 2'd2, 1'b0});
    add_row(ACT_READ,  32'h0000_1800, 1, {32'h0000_1800, 32'h0, 1'b0, 2'd3, 1'b0});
    // set 0 full: refresh, then evictions of dirty and clean lines
    add_row(ACT_READ,  32'h0000_0004, 0, '0);
    add_row(ACT_READ,  32'h0000_2000, 0, '0);
    add_row(ACT_WRITE, 32'h7FFF_F800, 0, '0);
    add_row(ACT_READ,  32'h0000_0000, 0, '0);
    add_row(ACT_WRITE, 32'h8000_0000, 0, '0);
    add_row(ACT_READ,  32'hFFFF_F800, 0, '0);
    // set 63 full, dirty top-tag line is the victim
    add_row(ACT_READ,  32'hFFFF_07E0, 0, '0);
    add_row(ACT_WRITE, 32'h0000_07E0, 0, '0);
    add_row(ACT_READ,  32'h0000_F7E0, 0, '0);
    add_row(ACT_WRITE, 32'h1234_57E0, 0, '0);
    add_row(ACT_READ,  32'hFFFF_FFE0, 0, '0);
    add_row(ACT_WRITE, 32'h5555_5555, 0, '0);
    add_row(ACT_READ,  32'hAAAA_AAAA, 0, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // upper data bits dropped, spare index ignored
    set_mode(32'hFFFF_FFFE);
    cfg_access(1'b1, UNUSED_REG_ADDR, 32'h0000_0001);
    cfg_access(1'b0, MODE_REG_ADDR, '0);

    foreach (directed_accesses[i]) begin
      row = directed_accesses[i];
      send_request(row.act, row.addr, row.known, row.res);
    end

    for (int p = 0; p < 4; p++) begin
      drain();
      case (p)
        0: set_mode(32'h0000_0001);
        1: set_mode(32'h0000_0000);
        2: set_mode(32'hFFFF_FFFF);
        default: set_mode(32'hFFFF_FFFE);
      endcase
      random_phase(PHASE_REQS);
    end

    in_tvalid <= 1'b0;
    while (awaited_lookups.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
